// ===== rtl/hvs_pkg.sv =====
// Shared types and constants of the histogram statistics block.
package hvs_pkg;

	// Default configuration of the block.
	localparam int MAX_VALUE_DEF  = 100;
	localparam int COUNT_BITS_DEF = 16;

	// Fraction bits of the average.
	localparam int FRAC_W = 8;

	// Bin index carried through the request queue; wide enough for a MAX_VALUE of up to 255.
	localparam int BIN_IDX_W = 8;

	// Widths of the sample and result ports.
	localparam int SAMPLE_W  = 7;
	localparam int CNT_OUT_W = 16;
	localparam int AVG_OUT_W = 15;
	localparam int VAL_OUT_W = 7;

	// Request queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	// Classified request kinds.
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DROP   = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [BIN_IDX_W-1:0] bin;
	} item_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] count;
		logic [AVG_OUT_W-1:0] average_q8;
		logic [VAL_OUT_W-1:0] highest;
		logic [VAL_OUT_W-1:0] lowest;
		logic [CNT_OUT_W-1:0] above_count;
		logic [CNT_OUT_W-1:0] below_count;
		logic                 empty_res;
		logic                 dropped;
	} res_t;

endpackage

// ===== rtl/hvs_front.sv =====
// Front end: accepts input requests and classifies them for the back end.
module hvs_front import hvs_pkg::*; #(
	parameter int MAX_VALUE = MAX_VALUE_DEF
) (
	input  logic                push,
	input  logic                full,
	input  logic                action,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                q_wr,
	output item_t               q_item
);

	logic [BIN_IDX_W-1:0] bin_ext;

	// A request is taken whenever the queue has room.
	assign q_wr = push && !full;

	assign bin_ext = BIN_IDX_W'(sample);

	// Finish requests go straight through; samples above the top bin are marked as drops.
	always_comb begin
		q_item.bin = bin_ext;
		if (action) begin
			q_item.op = OP_FINISH;
		end else if (bin_ext > BIN_IDX_W'(MAX_VALUE)) begin
			q_item.op = OP_DROP;
		end else begin
			q_item.op = OP_ADD;
		end
	end

endmodule

// ===== rtl/hvs_queue.sv =====
// Short request queue that decouples the front end from the back end.
module hvs_queue import hvs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output item_t rd_item,
	output logic  avail
);

	item_t              slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   fill_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (fill_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign avail   = (fill_q != '0);
	assign rd_item = slot_q[rd_ptr_q];
	assign do_wr   = wr && !full;
	assign do_rd   = rd && avail;

	// Storage slots carry no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= (Q_PTR_W + 1)'(fill_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				fill_q <= (Q_PTR_W + 1)'(fill_q - 1'b1);
			end
		end
	end

endmodule

// ===== rtl/hvs_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module hvs_div import hvs_pkg::*; #(
	parameter int DVD_W = 31,
	parameter int DVS_W = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	assign done     = done_q;
	assign quotient = quo_q;

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= STEP_W'(step_q - 1'b1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/hvs_back.sv =====
// Back end: bins samples into the histogram memory and builds the report.
module hvs_back import hvs_pkg::*; #(
	parameter int MAX_VALUE  = MAX_VALUE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t q_item,
	input  logic  q_avail,
	output logic  q_pop,
	output res_t  res,
	output logic  res_vld,
	input  logic  res_pop
);

	localparam int NUM_BINS = MAX_VALUE + 1;
	localparam int VAL_W    = $clog2(NUM_BINS);
	localparam int SCAN_W   = $clog2(NUM_BINS + 1);
	localparam int SUM_W    = COUNT_BITS + VAL_W;
	localparam int DVD_W    = SUM_W + FRAC_W;
	localparam int AVG_W    = VAL_W + FRAC_W;

	typedef enum logic [4:0] {
		ST_RUN   = 5'b00001,
		ST_SUM   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_SPLIT = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// Histogram memory with one valid bit per bin; an invalid bin reads as zero.
	logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
	logic [NUM_BINS-1:0]   bin_vld_q;
	logic [VAL_W-1:0]      rd_addr;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rd_vld_q;
	logic [COUNT_BITS-1:0] rd_val;

	logic [COUNT_BITS-1:0] total_q;
	logic                  drop_q;

	// Sample binning stage.
	logic                  add_vld_s1;
	logic [VAL_W-1:0]      add_idx_s1;
	logic                  byp_s1;
	logic [COUNT_BITS-1:0] byp_val_s1;
	logic [COUNT_BITS-1:0] add_old;
	logic [COUNT_BITS-1:0] add_new;

	// Request decode.
	logic             issue_add;
	logic             set_drop;
	logic             start_fin;
	logic [VAL_W-1:0] head_idx;

	// Histogram scans.
	logic [SCAN_W-1:0] scan_idx_q;
	logic              scan_issue;
	logic              scan_end;
	logic              scan_vld_s1;
	logic [VAL_W-1:0]  scan_idx_s1;
	logic [SUM_W-1:0]  prod;
	logic [SUM_W-1:0]  prod_s2;
	logic              prod_vld_s2;
	logic              sum_done;

	// Report accumulators.
	logic [SUM_W-1:0]      sum_q;
	logic                  found_q;
	logic [VAL_W-1:0]      hi_q;
	logic [VAL_W-1:0]      lo_q;
	logic [AVG_W-1:0]      avg_q;
	logic [VAL_W-1:0]      avg_int;
	logic [COUNT_BITS-1:0] above_q;
	logic [COUNT_BITS-1:0] below_q;
	logic                  emp_q;

	// Divider hookup.
	logic             div_start;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	// Result register.
	res_t res_q;
	logic res_vld_q;
	logic res_load;

	assign head_idx = VAL_W'(q_item.bin);
	assign rd_val   = rd_vld_q ? rd_data_q : '0;
	assign add_old  = byp_s1 ? byp_val_s1 : rd_val;
	assign add_new  = COUNT_BITS'(add_old + 1'b1);
	assign avg_int  = avg_q[AVG_W-1:FRAC_W];

	// Decode the request at the head of the queue while the histogram is live.
	always_comb begin
		q_pop     = 1'b0;
		issue_add = 1'b0;
		set_drop  = 1'b0;
		start_fin = 1'b0;
		if ((state_q == ST_RUN) && q_avail) begin
			case (q_item.op)
				OP_ADD: begin
					q_pop = 1'b1;
					if (total_q == '1) begin
						set_drop = 1'b1;
					end else begin
						issue_add = 1'b1;
					end
				end
				OP_DROP: begin
					q_pop    = 1'b1;
					set_drop = 1'b1;
				end
				OP_FINISH: begin
					// Wait until the last binned sample has been written back.
					if (!add_vld_s1) begin
						q_pop     = 1'b1;
						start_fin = 1'b1;
					end
				end
				default: begin
					q_pop = 1'b1;
				end
			endcase
		end
	end

	// Scan control.
	assign scan_end   = (scan_idx_q == SCAN_W'(NUM_BINS));
	assign scan_issue = ((state_q == ST_SUM) || (state_q == ST_SPLIT)) && !scan_end;
	assign sum_done   = (state_q == ST_SUM) && scan_end && !scan_vld_s1 && !prod_vld_s2;
	assign div_start  = sum_done;
	assign rd_addr    = (state_q == ST_RUN) ? head_idx : scan_idx_q[VAL_W-1:0];
	assign prod       = SUM_W'(rd_val) * SUM_W'(scan_idx_s1);
	assign res_load   = (state_q == ST_EMIT) && (!res_vld_q || res_pop);

	// Memory read port, registered.
	always_ff @(posedge clk) begin
		rd_data_q <= bin_mem[rd_addr];
		rd_vld_q  <= bin_vld_q[rd_addr];
	end

	// Memory write port: the incremented bin count.
	always_ff @(posedge clk) begin
		if (add_vld_s1) begin
			bin_mem[add_idx_s1] <= add_new;
		end
	end

	// Binning pipeline payload; a back-to-back hit on the same bin bypasses the memory.
	always_ff @(posedge clk) begin
		add_idx_s1 <= head_idx;
		byp_s1     <= add_vld_s1 && (add_idx_s1 == head_idx);
		byp_val_s1 <= add_new;
	end

	// Scan pipeline payload and report accumulators.
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q[VAL_W-1:0];
		prod_s2     <= prod;
		if (start_fin) begin
			sum_q   <= '0;
			found_q <= 1'b0;
			hi_q    <= '0;
			lo_q    <= '0;
			avg_q   <= '0;
			above_q <= '0;
			below_q <= '0;
			emp_q   <= (total_q == '0);
		end else begin
			if (prod_vld_s2) begin
				sum_q <= SUM_W'(sum_q + prod_s2);
			end
			if (scan_vld_s1 && (state_q == ST_SUM) && (rd_val != '0)) begin
				hi_q <= scan_idx_s1;
				if (!found_q) begin
					lo_q    <= scan_idx_s1;
					found_q <= 1'b1;
				end
			end
			if (div_done) begin
				avg_q <= AVG_W'(div_quo);
			end
			if (scan_vld_s1 && (state_q == ST_SPLIT)) begin
				if (scan_idx_s1 > avg_int) begin
					above_q <= COUNT_BITS'(above_q + rd_val);
				end else begin
					below_q <= COUNT_BITS'(below_q + rd_val);
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.count       <= CNT_OUT_W'(total_q);
			res_q.average_q8  <= AVG_OUT_W'(avg_q);
			res_q.highest     <= VAL_OUT_W'(hi_q);
			res_q.lowest      <= VAL_OUT_W'(lo_q);
			res_q.above_count <= CNT_OUT_W'(above_q);
			res_q.below_count <= CNT_OUT_W'(below_q);
			res_q.empty_res   <= emp_q;
			res_q.dropped     <= drop_q;
		end
	end

	// Control state: sequencer, counters, valid bits and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			bin_vld_q   <= '0;
			total_q     <= '0;
			drop_q      <= 1'b0;
			add_vld_s1  <= 1'b0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			prod_vld_s2 <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			add_vld_s1  <= issue_add;
			scan_vld_s1 <= scan_issue;
			prod_vld_s2 <= scan_vld_s1 && (state_q == ST_SUM);
			if (scan_issue) begin
				scan_idx_q <= SCAN_W'(scan_idx_q + 1'b1);
			end
			if (issue_add) begin
				total_q <= COUNT_BITS'(total_q + 1'b1);
			end
			if (set_drop) begin
				drop_q <= 1'b1;
			end
			if (add_vld_s1) begin
				bin_vld_q[add_idx_s1] <= 1'b1;
			end
			if (res_pop && res_vld_q && !res_load) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				ST_RUN: begin
					if (start_fin) begin
						scan_idx_q <= '0;
						state_q    <= (total_q == '0) ? ST_EMIT : ST_SUM;
					end
				end
				ST_SUM: begin
					if (sum_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						scan_idx_q <= '0;
						state_q    <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (scan_end && !scan_vld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Hand over the report and clear the store for the next set.
					if (res_load) begin
						res_vld_q <= 1'b1;
						bin_vld_q <= '0;
						total_q   <= '0;
						drop_q    <= 1'b0;
						state_q   <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	hvs_div #(
		.DVD_W (DVD_W),
		.DVS_W (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_q, {FRAC_W{1'b0}}}),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign res     = res_q;
	assign res_vld = res_vld_q;

endmodule

// ===== rtl/histogram_value_statistics_core.sv =====
// Top level of the histogram statistics block.
//
// Input queue: an action 0 request bins a sample of 0 to MAX_VALUE; larger samples,
// and samples past a full count, are dropped and flagged. An action 1 request closes
// the set and produces one report. A request is taken when push is high and full low.
// Result queue: the report waits on the result ports while empty is low and leaves
// when pop is high.
// Samples are binned one per cycle, while the back end is in its run state and the
// queue holds requests, through a read-modify-write of the histogram memory, whose
// single read port sets that rate. A finish request waits for the last sample write,
// then scans all MAX_VALUE+1 bins for the sum, highest and lowest, runs a bit-serial
// divide of COUNT_BITS+clog2(MAX_VALUE+1)+8 steps, and scans the bins again to split
// the counts around the average. An empty set skips the scans and the divide and goes
// straight to the report. Meanwhile a four-deep request queue keeps taking input
// until it fills.
// Reset empties both queues and clears the histogram, count and drop flag at once.
// If the receiver does not pop, the finished report stays put; binning continues until
// the next finish request, and the back end then holds that next report.
module histogram_value_statistics_core import hvs_pkg::*; #(
	parameter int MAX_VALUE  = MAX_VALUE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 empty,
	input  logic                 pop,
	output logic [CNT_OUT_W-1:0] count,
	output logic [AVG_OUT_W-1:0] average_q8,
	output logic [VAL_OUT_W-1:0] highest,
	output logic [VAL_OUT_W-1:0] lowest,
	output logic [CNT_OUT_W-1:0] above_count,
	output logic [CNT_OUT_W-1:0] below_count,
	output logic                 empty_res,
	output logic                 dropped
);

	logic  q_wr;
	item_t wr_item;
	logic  q_rd;
	item_t rd_item;
	logic  q_avail;
	res_t  res;
	logic  res_vld;

	hvs_front #(
		.MAX_VALUE (MAX_VALUE)
	) u_front (
		.push   (push),
		.full   (full),
		.action (action),
		.sample (sample),
		.q_wr   (q_wr),
		.q_item (wr_item)
	);

	hvs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (wr_item),
		.full    (full),
		.rd      (q_rd),
		.rd_item (rd_item),
		.avail   (q_avail)
	);

	hvs_back #(
		.MAX_VALUE  (MAX_VALUE),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (rd_item),
		.q_avail (q_avail),
		.q_pop   (q_rd),
		.res     (res),
		.res_vld (res_vld),
		.res_pop (pop)
	);

	// Result ports.
	assign empty       = !res_vld;
	assign count       = res.count;
	assign average_q8  = res.average_q8;
	assign highest     = res.highest;
	assign lowest      = res.lowest;
	assign above_count = res.above_count;
	assign below_count = res.below_count;
	assign empty_res   = res.empty_res;
	assign dropped     = res.dropped;

endmodule

// ===== rtl/hvs_chk.sv =====
// Port-level checker for the histogram statistics block, bound to the top level.
module hvs_chk import hvs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [CNT_OUT_W-1:0] count,
	input logic [AVG_OUT_W-1:0] average_q8,
	input logic [VAL_OUT_W-1:0] highest,
	input logic [VAL_OUT_W-1:0] lowest,
	input logic [CNT_OUT_W-1:0] above_count,
	input logic [CNT_OUT_W-1:0] below_count,
	input logic                 empty_res,
	input logic                 dropped
);

	// No report is offered in the cycle after reset has been seen.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result offered during reset");

	// A waiting report stays offered, and its count, average, split counts and drop flag hold until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(count) && $stable(average_q8)
			&& $stable(above_count) && $stable(below_count) && $stable(dropped)))
		else $error("waiting report changed");

	// An empty set reports all statistics as zero.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && empty_res) |-> (count == '0 && average_q8 == '0 && highest == '0
			&& lowest == '0 && above_count == '0 && below_count == '0))
		else $error("empty report carries statistics");

	// Every counted sample falls on one side of the average.
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !empty_res) |-> (CNT_OUT_W'(above_count + below_count) == count))
		else $error("above and below counts do not add up to the count");

endmodule

bind histogram_value_statistics_core hvs_chk u_chk (.*);
